>>> rtl/core/iowt_pkg.sv
// ----------------------------------------------------------------------------
// iowt_pkg
// Shared constants and controller/datapath interface types for the in-order
// watermark tracker.
// ----------------------------------------------------------------------------
package iowt_pkg;

   // Field widths.
   localparam int SEQ_W = 64;
   localparam int WM_W  = 64;
   localparam int CNT_W = 7;
   localparam int ACT_W = 5;

   // Origin table and reorder window sizes.
   localparam int MAX_ORIGINS  = 16;
   localparam int ORIG_W       = $clog2(MAX_ORIGINS);
   localparam int WINDOW_DEPTH = 64;
   localparam int WIN_W        = $clog2(WINDOW_DEPTH);

   // Reset value of the active origin count.
   localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(16);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch an accepted item
      logic insert;    // window check and insert into the reorder window
      logic probe;     // read the window slot of the next sequence number
      logic apply;     // apply the probed entry to its origin
      logic scan;      // one step of the minimum walk
      logic emit;      // load the result register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic next_valid;  // next sequence number is pending
      logic scan_last;   // minimum walk is at the last origin
   } dp_sts_type;

endpackage

>>> rtl/core/iowt_datapath.sv
// ----------------------------------------------------------------------------
// iowt_datapath
// Item registers, reorder window memory with valid bits, origin watermark
// table, running minimum and result register.
// ----------------------------------------------------------------------------
module iowt_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  iowt_pkg::dp_cmd_type        cmd,
   output iowt_pkg::dp_sts_type        sts,
   input  logic [63:0]                 req_sequence_number,
   input  logic [3:0]                  req_origin_index,
   input  logic [63:0]                 req_watermark_value,
   input  logic                        csr_write_enable,
   input  logic [4:0]                  csr_write_data,
   output logic [63:0]                 rsp_current_watermark,
   output logic [6:0]                  rsp_applied_count,
   output logic                        rsp_rejected
);
   import iowt_pkg::*;

   // Captured item.
   logic [SEQ_W-1:0]  seq_ff;
   logic [ORIG_W-1:0] orig_ff;
   logic [WM_W-1:0]   wm_ff;

   // Tracker state.
   logic [SEQ_W-1:0]        last_ff;
   logic [WINDOW_DEPTH-1:0] pend_valid_ff;
   logic [ACT_W-1:0]        active_ff;
   logic [WM_W-1:0]         origin_wm_ff [MAX_ORIGINS];

   // Reorder window memory: origin and watermark per slot.
   logic [ORIG_W+WM_W-1:0] pend_mem_ff [WINDOW_DEPTH];
   logic [ORIG_W+WM_W-1:0] mem_rd_ff;

   // Per-item working registers.
   logic [CNT_W-1:0]  count_ff;
   logic              rej_ff;
   logic [WM_W-1:0]   min_ff;
   logic [ORIG_W-1:0] idx_ff;

   // Result register.
   logic [WM_W-1:0]  out_wm_ff;
   logic [CNT_W-1:0] out_cnt_ff;
   logic             out_rej_ff;

   logic [SEQ_W-1:0]  next_seq;
   logic [SEQ_W-1:0]  seq_gap;
   logic [WIN_W-1:0]  ins_slot;
   logic [WIN_W-1:0]  next_slot;
   logic              in_window;
   logic              ins_ok;
   logic [ORIG_W-1:0] rd_orig;
   logic [WM_W-1:0]   rd_wm;
   logic [WM_W-1:0]   scan_wm;
   logic              scan_take;

   // Window test: the item is due within the next WINDOW_DEPTH numbers.
   assign next_seq  = last_ff + SEQ_W'(1);
   assign seq_gap   = seq_ff - next_seq;
   assign in_window = (seq_gap < SEQ_W'(WINDOW_DEPTH));
   assign ins_slot  = seq_ff[WIN_W-1:0];
   assign next_slot = next_seq[WIN_W-1:0];
   assign ins_ok    = in_window && !pend_valid_ff[ins_slot];

   assign rd_orig = mem_rd_ff[ORIG_W+WM_W-1:WM_W];
   assign rd_wm   = mem_rd_ff[WM_W-1:0];

   // One origin per scan step; origins at or beyond the active count are skipped.
   assign scan_wm   = origin_wm_ff[idx_ff];
   assign scan_take = ({1'b0, idx_ff} < active_ff) && (scan_wm < min_ff);

   assign sts.next_valid = pend_valid_ff[next_slot];
   assign sts.scan_last  = (idx_ff == ORIG_W'(MAX_ORIGINS - 1));

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_write_enable) begin
         active_ff <= csr_write_data;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff  <= req_sequence_number;
         orig_ff <= req_origin_index;
         wm_ff   <= req_watermark_value;
      end
   end

   // Last applied sequence number and window valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff       <= '0;
         pend_valid_ff <= '0;
      end else begin
         if (cmd.insert && ins_ok) begin
            pend_valid_ff[ins_slot] <= 1'b1;
         end
         if (cmd.apply) begin
            pend_valid_ff[next_slot] <= 1'b0;
            last_ff                  <= next_seq;
         end
      end
   end

   // Reorder window memory: write on insert, registered read on probe.
   always_ff @(posedge clock) begin
      if (cmd.insert && ins_ok) begin
         pend_mem_ff[ins_slot] <= {orig_ff, wm_ff};
      end
      if (cmd.probe) begin
         mem_rd_ff <= pend_mem_ff[next_slot];
      end
   end

   // Origin watermark table.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ORIGINS; i++) begin
            origin_wm_ff[i] <= '0;
         end
      end else if (cmd.apply) begin
         origin_wm_ff[rd_orig] <= rd_wm;
      end
   end

   // Per-item counters, reject flag and running minimum.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_ff + CNT_W'(1);
      end
      if (cmd.insert) begin
         rej_ff <= !ins_ok;
         min_ff <= '1;
         idx_ff <= '0;
      end else if (cmd.scan) begin
         if (scan_take) begin
            min_ff <= scan_wm;
         end
         idx_ff <= idx_ff + ORIG_W'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_wm_ff  <= min_ff;
         out_cnt_ff <= count_ff;
         out_rej_ff <= rej_ff;
      end
   end

   assign rsp_current_watermark = out_wm_ff;
   assign rsp_applied_count     = out_cnt_ff;
   assign rsp_rejected          = out_rej_ff;

endmodule

>>> rtl/core/iowt_controller.sv
// ----------------------------------------------------------------------------
// iowt_controller
// Sequences one item through insert, in-order drain, minimum walk and result
// hand-off, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module iowt_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output iowt_pkg::dp_cmd_type  cmd,
   input  iowt_pkg::dp_sts_type  sts
);
   import iowt_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_PROBE  = 3'd2;
   localparam logic [2:0] ST_APPLY  = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // The result register can take a new result once the old one is gone.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_PROBE;
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
            state_in  = sts.next_valid ? ST_APPLY : ST_SCAN;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_PROBE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/in_order_watermark_tracker.sv
// ----------------------------------------------------------------------------
// in_order_watermark_tracker
// Reorders sequence-tagged watermark updates, applies them in strict order
// to per-origin slots and reports the minimum watermark over active origins.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  sequence_number, origin_index,
//                                            watermark_value
//   rsp      out        rsp_valid/rsp_ready  current_watermark, applied_count,
//                                            rejected
//   csr      in         csr_write_enable     active origin count (5 bits)
//
// One item at a time: an insert, then a probe and an apply per applied update
// plus a final probe, the minimum walk over the whole origin table and a load
// of the result register; the next item can be accepted in the cycle after
// the result is loaded.
// The drain loop is bound by the single registered read port of the window.
// Synchronous reset clears all valid bits, origins and the sequence at once.
// A stalled result stays in the output register; the next item is taken once
// the result is loaded, and waits at the end only if the register is full.
//
module in_order_watermark_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_sequence_number,
   input  logic [3:0]  req_origin_index,
   input  logic [63:0] req_watermark_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_current_watermark,
   output logic [6:0]  rsp_applied_count,
   output logic        rsp_rejected,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data
);
   import iowt_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencing and handshakes.
   iowt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Storage and arithmetic.
   iowt_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_sequence_number   (req_sequence_number),
      .req_origin_index      (req_origin_index),
      .req_watermark_value   (req_watermark_value),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .rsp_current_watermark (rsp_current_watermark),
      .rsp_applied_count     (rsp_applied_count),
      .rsp_rejected          (rsp_rejected)
   );

endmodule
